// ===== hw/rtl/pit_pkg.sv =====
// Shared widths, types, register indexes and helpers of the point-in-triangle test.
package pit_pkg;

   // Coordinate and arithmetic widths
   localparam int COORD_BITS  = 16;
   localparam int VERTEX_W    = 3 * COORD_BITS;
   localparam int DIFF_W      = COORD_BITS + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int DOT_W       = PROD_W + 2;
   localparam int LO_W        = DOT_W / 2;
   localparam int HI_W        = DOT_W - LO_W;
   localparam int WIDE_W      = 2 * DOT_W;

   // Pipeline depth from accept to result register
   localparam int STAGES      = 7;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_A    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_B    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_C    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANAR_MODE = 2'd3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [DOT_W-1:0]      dot_type;
   typedef logic signed [WIDE_W-1:0]     wide_type;

   typedef struct packed {
      dot_type uu;
      dot_type uv;
      dot_type vv;
      dot_type uw;
      dot_type vw;
   } dots_type;

   typedef struct packed {
      logic inside_res;
      logic degenerate;
      logic on_vertex;
   } result_type;

   // Pick coordinate sel (0 = x, 1 = y, 2 = z) out of a packed vertex
   function automatic coord_type vertex_coord(logic [VERTEX_W-1:0] vertex, logic [1:0] sel);
      return vertex[sel * COORD_BITS +: COORD_BITS];
   endfunction

   // Exact difference of two coordinates
   function automatic diff_type coord_diff(coord_type p, coord_type q);
      return DIFF_W'(p) - DIFF_W'(q);
   endfunction

endpackage

// ===== hw/rtl/point_in_triangle_test.sv =====
// Top level of the barycentric point-in-triangle test pipeline.
//
// Usage:
//   Load the triangle through the csr_ port: index 0, 1, 2 take vertices A, B, C as
//   packed signed x, y, z (x in the low bits), index 3 takes the planar mode bit.
//   Writes are registered; change them only while no transaction is in flight.
//   Each point transaction on the req_ channel yields exactly one rsp_ transaction
//   with inside_res, degenerate and on_vertex, in order.
// Pipeline: seven register stages (differences, axis products, dot sums, partial
//   products, product assembly, D/S/T, decision); the accepting edge loads the first.
// Throughput: one point per cycle while req_ready is high; every stage is a register with its own valid bit.
// Stalls: a stage advances when it is empty or its successor advances, so bubbles
//   close up and new points are taken while a finished result waits on rsp_ready.
//   req_ready drops only once all seven stages hold points.
// Reset: clears all valid bits and the configuration registers (all vertices at the
//   origin, 3D mode).
module point_in_triangle_test (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pit_pkg::coord_type                req_point_x,
   input  pit_pkg::coord_type                req_point_y,
   input  pit_pkg::coord_type                req_point_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_inside_res,
   output logic                              rsp_degenerate,
   output logic                              rsp_on_vertex,
   input  logic                              csr_write_en,
   input  logic [pit_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pit_pkg::VERTEX_W-1:0]      csr_wdata
);
   import pit_pkg::*;

   logic [VERTEX_W-1:0] vertex_a_ff, vertex_b_ff, vertex_c_ff;
   logic [VERTEX_W-1:0] vertex_a_in, vertex_b_in, vertex_c_in;
   logic                planar_ff, planar_in;
   logic [STAGES-1:0]   valid_ff, valid_in, stage_en;
   dots_type            dots;
   logic                onv_dot, onv4_ff, onv5_ff;
   wide_type            p_uu_vv, p_uv_uv, p_vv_uw, p_uv_vw, p_uu_vw, p_uv_uw;
   result_type          result;

   // Configuration registers
   always_comb begin
      vertex_a_in = vertex_a_ff;
      vertex_b_in = vertex_b_ff;
      vertex_c_in = vertex_c_ff;
      planar_in   = planar_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_VERTEX_A:    vertex_a_in = csr_wdata;
            CSR_VERTEX_B:    vertex_b_in = csr_wdata;
            CSR_VERTEX_C:    vertex_c_in = csr_wdata;
            CSR_PLANAR_MODE: planar_in   = csr_wdata[0];
            default:         planar_in   = planar_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_ff <= '0;
         vertex_b_ff <= '0;
         vertex_c_ff <= '0;
         planar_ff   <= 1'b0;
      end else begin
         vertex_a_ff <= vertex_a_in;
         vertex_b_ff <= vertex_b_in;
         vertex_c_ff <= vertex_c_in;
         planar_ff   <= planar_in;
      end
   end

   // Stage enables: advance a stage when it is empty or the next one advances
   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Stages one to three: edge vectors and dot products
   pit_dot u_dot (
      .clock       (clock),
      .stage_en    (stage_en[2:0]),
      .vertex_a    (vertex_a_ff),
      .vertex_b    (vertex_b_ff),
      .vertex_c    (vertex_c_ff),
      .planar_mode (planar_ff),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .point_z     (req_point_z),
      .dots        (dots),
      .on_vertex   (onv_dot)
   );

   // Stages four and five: the six wide products
   pit_wmul u_mul_uu_vv (.clock(clock), .stage_en(stage_en[4:3]),
                         .op_a(dots.uu), .op_b(dots.vv), .product(p_uu_vv));
   pit_wmul u_mul_uv_uv (.clock(clock), .stage_en(stage_en[4:3]),
                         .op_a(dots.uv), .op_b(dots.uv), .product(p_uv_uv));
   pit_wmul u_mul_vv_uw (.clock(clock), .stage_en(stage_en[4:3]),
                         .op_a(dots.vv), .op_b(dots.uw), .product(p_vv_uw));
   pit_wmul u_mul_uv_vw (.clock(clock), .stage_en(stage_en[4:3]),
                         .op_a(dots.uv), .op_b(dots.vw), .product(p_uv_vw));
   pit_wmul u_mul_uu_vw (.clock(clock), .stage_en(stage_en[4:3]),
                         .op_a(dots.uu), .op_b(dots.vw), .product(p_uu_vw));
   pit_wmul u_mul_uv_uw (.clock(clock), .stage_en(stage_en[4:3]),
                         .op_a(dots.uv), .op_b(dots.uw), .product(p_uv_uw));

   // Carry the vertex match alongside the multipliers
   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         onv4_ff <= onv_dot;
      end
      if (stage_en[4]) begin
         onv5_ff <= onv4_ff;
      end
   end

   // Stages six and seven: numerators, denominator and the decision
   pit_eval u_eval (
      .clock     (clock),
      .stage_en  (stage_en[6:5]),
      .p_uu_vv   (p_uu_vv),
      .p_uv_uv   (p_uv_uv),
      .p_vv_uw   (p_vv_uw),
      .p_uv_vw   (p_uv_vw),
      .p_uu_vw   (p_uu_vw),
      .p_uv_uw   (p_uv_uw),
      .on_vertex (onv5_ff),
      .result    (result)
   );

   assign req_ready      = stage_en[0];
   assign rsp_valid      = valid_ff[STAGES-1];
   assign rsp_inside_res = result.inside_res;
   assign rsp_degenerate = result.degenerate;
   assign rsp_on_vertex  = result.on_vertex;

endmodule

// ===== hw/rtl/pit_dot.sv =====
// Edge vectors, vertex match and the five dot products, three pipeline stages.
module pit_dot (
   input  logic                           clock,
   input  logic [2:0]                     stage_en,
   input  logic [pit_pkg::VERTEX_W-1:0]   vertex_a,
   input  logic [pit_pkg::VERTEX_W-1:0]   vertex_b,
   input  logic [pit_pkg::VERTEX_W-1:0]   vertex_c,
   input  logic                           planar_mode,
   input  pit_pkg::coord_type             point_x,
   input  pit_pkg::coord_type             point_y,
   input  pit_pkg::coord_type             point_z,
   output pit_pkg::dots_type              dots,
   output logic                           on_vertex
);
   import pit_pkg::*;

   coord_type  point_c [3];
   diff_type   u_in [3], v_in [3], w_in [3];
   diff_type   u_ff [3], v_ff [3], w_ff [3];
   logic       onv1_in, onv1_ff, onv2_ff, on_vertex_ff;
   logic       planar_ff;
   prod_type   uu_in [3], uv_in [3], vv_in [3], uw_in [3], vw_in [3];
   prod_type   uu_ff [3], uv_ff [3], vv_ff [3], uw_ff [3], vw_ff [3];
   dots_type   dots_in, dots_ff;

   // Stage one: differences against vertex A and the x/y vertex match
   always_comb begin
      point_c[0] = point_x;
      point_c[1] = point_y;
      point_c[2] = point_z;
      for (int i = 0; i < 3; i++) begin
         u_in[i] = coord_diff(vertex_coord(vertex_b, 2'(i)), vertex_coord(vertex_a, 2'(i)));
         v_in[i] = coord_diff(vertex_coord(vertex_c, 2'(i)), vertex_coord(vertex_a, 2'(i)));
         w_in[i] = coord_diff(point_c[i], vertex_coord(vertex_a, 2'(i)));
      end
      onv1_in = (point_x == vertex_coord(vertex_a, 2'd0) &&
                 point_y == vertex_coord(vertex_a, 2'd1)) ||
                (point_x == vertex_coord(vertex_b, 2'd0) &&
                 point_y == vertex_coord(vertex_b, 2'd1)) ||
                (point_x == vertex_coord(vertex_c, 2'd0) &&
                 point_y == vertex_coord(vertex_c, 2'd1));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         u_ff      <= u_in;
         v_ff      <= v_in;
         w_ff      <= w_in;
         onv1_ff   <= onv1_in;
         planar_ff <= planar_mode;
      end
   end

   // Stage two: per-axis products, drop the z terms in planar mode
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (planar_ff && i == 2) begin
            uu_in[i] = '0;
            uv_in[i] = '0;
            vv_in[i] = '0;
            uw_in[i] = '0;
            vw_in[i] = '0;
         end else begin
            uu_in[i] = u_ff[i] * u_ff[i];
            uv_in[i] = u_ff[i] * v_ff[i];
            vv_in[i] = v_ff[i] * v_ff[i];
            uw_in[i] = u_ff[i] * w_ff[i];
            vw_in[i] = v_ff[i] * w_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         uu_ff   <= uu_in;
         uv_ff   <= uv_in;
         vv_ff   <= vv_in;
         uw_ff   <= uw_in;
         vw_ff   <= vw_in;
         onv2_ff <= onv1_ff;
      end
   end

   // Stage three: sum the axis products into dot products
   always_comb begin
      dots_in.uu = DOT_W'(uu_ff[0]) + DOT_W'(uu_ff[1]) + DOT_W'(uu_ff[2]);
      dots_in.uv = DOT_W'(uv_ff[0]) + DOT_W'(uv_ff[1]) + DOT_W'(uv_ff[2]);
      dots_in.vv = DOT_W'(vv_ff[0]) + DOT_W'(vv_ff[1]) + DOT_W'(vv_ff[2]);
      dots_in.uw = DOT_W'(uw_ff[0]) + DOT_W'(uw_ff[1]) + DOT_W'(uw_ff[2]);
      dots_in.vw = DOT_W'(vw_ff[0]) + DOT_W'(vw_ff[1]) + DOT_W'(vw_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         dots_ff      <= dots_in;
         on_vertex_ff <= onv2_ff;
      end
   end

   assign dots      = dots_ff;
   assign on_vertex = on_vertex_ff;

endmodule

// ===== hw/rtl/pit_wmul.sv =====
// Two-stage signed multiplier of two dot products, split into half-width partial products.
module pit_wmul (
   input  logic              clock,
   input  logic [1:0]        stage_en,
   input  pit_pkg::dot_type  op_a,
   input  pit_pkg::dot_type  op_b,
   output pit_pkg::wide_type product
);
   import pit_pkg::*;

   logic signed [HI_W-1:0]      a_hi, b_hi;
   logic signed [LO_W:0]        a_lo, b_lo;
   logic signed [2*HI_W-1:0]    pp_hh_in, pp_hh_ff;
   logic signed [HI_W+LO_W:0]   pp_hl_in, pp_hl_ff, pp_lh_in, pp_lh_ff;
   logic [2*LO_W-1:0]           pp_ll_in, pp_ll_ff;
   wide_type                    term_hh, term_hl, term_lh, term_ll;
   wide_type                    product_in, product_ff;

   // Stage one: four partial products, signed high halves, unsigned low halves
   always_comb begin
      a_hi     = op_a[DOT_W-1:LO_W];
      b_hi     = op_b[DOT_W-1:LO_W];
      a_lo     = $signed({1'b0, op_a[LO_W-1:0]});
      b_lo     = $signed({1'b0, op_b[LO_W-1:0]});
      pp_hh_in = a_hi * b_hi;
      pp_hl_in = a_hi * b_lo;
      pp_lh_in = a_lo * b_hi;
      pp_ll_in = op_a[LO_W-1:0] * op_b[LO_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pp_hh_ff <= pp_hh_in;
         pp_hl_ff <= pp_hl_in;
         pp_lh_ff <= pp_lh_in;
         pp_ll_ff <= pp_ll_in;
      end
   end

   // Stage two: align and add the partial products
   always_comb begin
      term_hh    = WIDE_W'(pp_hh_ff) <<< (2 * LO_W);
      term_hl    = WIDE_W'(pp_hl_ff) <<< LO_W;
      term_lh    = WIDE_W'(pp_lh_ff) <<< LO_W;
      term_ll    = $signed(WIDE_W'(pp_ll_ff));
      product_in = term_hh + term_hl + term_lh + term_ll;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ===== hw/rtl/pit_eval.sv =====
// Denominator and numerators, then the inside and degenerate decisions, two stages.
module pit_eval (
   input  logic                clock,
   input  logic [1:0]          stage_en,
   input  pit_pkg::wide_type   p_uu_vv,
   input  pit_pkg::wide_type   p_uv_uv,
   input  pit_pkg::wide_type   p_vv_uw,
   input  pit_pkg::wide_type   p_uv_vw,
   input  pit_pkg::wide_type   p_uu_vw,
   input  pit_pkg::wide_type   p_uv_uw,
   input  logic                on_vertex,
   output pit_pkg::result_type result
);
   import pit_pkg::*;

   wide_type   den_in, den_ff, num_s_in, num_s_ff, num_t_in, num_t_ff;
   wide_type   slack;
   logic       onv_ff;
   result_type result_in, result_ff;

   // Stage one: D, S and T
   always_comb begin
      den_in   = p_uu_vv - p_uv_uv;
      num_s_in = p_vv_uw - p_uv_vw;
      num_t_in = p_uu_vw - p_uv_uw;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         den_ff   <= den_in;
         num_s_ff <= num_s_in;
         num_t_ff <= num_t_in;
         onv_ff   <= on_vertex;
      end
   end

   // Stage two: inside when D is nonzero, S and T nonnegative and S + T <= D
   always_comb begin
      slack                = den_ff - (num_s_ff + num_t_ff);
      result_in.degenerate = (den_ff == '0);
      result_in.inside_res = !result_in.degenerate && !num_s_ff[WIDE_W-1] &&
                             !num_t_ff[WIDE_W-1] && !slack[WIDE_W-1];
      result_in.on_vertex  = onv_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule
